>>> hw/rtl/bbps_pkg.sv
// Package with the constants, codes and tone helpers of the buzzer beep pattern sequencer.
package bbps_pkg;

   // Build-time settings.
   localparam int unsigned CLOCK_HZ         = 12000000;
   localparam int unsigned ALARM_LOOP_TICKS = 1000;
   localparam int unsigned SILENT_DIV       = 65536;

   // Field widths.
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned COUNT_W  = 15;
   localparam int unsigned HZ_W     = 10;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned HIGH_W   = 15;
   localparam int unsigned PHASE_W  = 10;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_TICK        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_VALID_KEY   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INVALID_KEY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SET_KEY     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_TIME    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SET_ALARM   = 3'd5;

   // Key beep kinds.
   localparam logic [KIND_W-1:0] KEY_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KEY_VALID   = 2'd1;
   localparam logic [KIND_W-1:0] KEY_INVALID = 2'd2;
   localparam logic [KIND_W-1:0] KEY_SERVICE = 2'd3;

   // Alarm kinds; the fourth code is stored but plays as silence.
   localparam logic [KIND_W-1:0] ALARM_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] ALARM_WARNING = 2'd1;
   localparam logic [KIND_W-1:0] ALARM_TIPS    = 2'd2;

   // Tones in hertz.
   localparam logic [HZ_W-1:0] HZ_SILENT = 10'd0;
   localparam logic [HZ_W-1:0] HZ_200    = 10'd200;
   localparam logic [HZ_W-1:0] HZ_300    = 10'd300;
   localparam logic [HZ_W-1:0] HZ_333    = 10'd333;
   localparam logic [HZ_W-1:0] HZ_500    = 10'd500;
   localparam logic [HZ_W-1:0] HZ_666    = 10'd666;

   // Key beep timing.
   localparam logic [COUNT_W-1:0] VALID_TICKS     = 15'd10;
   localparam logic [COUNT_W-1:0] INVALID_TICKS   = 15'd40;
   localparam logic [COUNT_W-1:0] INVALID_GAP_HI  = 15'd27;
   localparam logic [COUNT_W-1:0] INVALID_GAP_LO  = 15'd13;
   localparam logic [COUNT_W-1:0] SERVICE_RELOAD  = 15'd2;

   // PWM periods, worked out at elaboration.
   localparam int unsigned PER_SILENT_I = CLOCK_HZ / SILENT_DIV;
   localparam int unsigned PER_200_I    = CLOCK_HZ / 200;
   localparam int unsigned PER_300_I    = CLOCK_HZ / 300;
   localparam int unsigned PER_333_I    = CLOCK_HZ / 333;
   localparam int unsigned PER_500_I    = CLOCK_HZ / 500;
   localparam int unsigned PER_666_I    = CLOCK_HZ / 666;
   localparam logic [PERIOD_W-1:0] PER_SILENT = PER_SILENT_I[PERIOD_W-1:0];
   localparam logic [PERIOD_W-1:0] PER_200    = PER_200_I[PERIOD_W-1:0];
   localparam logic [PERIOD_W-1:0] PER_300    = PER_300_I[PERIOD_W-1:0];
   localparam logic [PERIOD_W-1:0] PER_333    = PER_333_I[PERIOD_W-1:0];
   localparam logic [PERIOD_W-1:0] PER_500    = PER_500_I[PERIOD_W-1:0];
   localparam logic [PERIOD_W-1:0] PER_666    = PER_666_I[PERIOD_W-1:0];

   // Alarm burst windows: a burst covers start <= phase < stop.
   localparam int unsigned BURSTS = 10;
   localparam logic [PHASE_W-1:0] BURST_START [BURSTS] = '{
      10'd0, 10'd24, 10'd48, 10'd88, 10'd112, 10'd208, 10'd232, 10'd256, 10'd296, 10'd320};
   localparam logic [PHASE_W-1:0] BURST_STOP [BURSTS] = '{
      10'd16, 10'd40, 10'd64, 10'd104, 10'd128, 10'd224, 10'd248, 10'd272, 10'd312, 10'd336};

   // Result word.
   typedef struct packed {
      logic                tone_on;
      logic [HZ_W-1:0]     tone_hz;
      logic [PERIOD_W-1:0] period_count;
      logic [HIGH_W-1:0]   high_count;
      logic                pwm_written;
      logic [KIND_W-1:0]   key_type_now;
      logic [KIND_W-1:0]   alarm_type_now;
   } rsp_type;

   function automatic logic burst_on(input logic [PHASE_W-1:0] ph);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < BURSTS; i++) begin
         if (ph >= BURST_START[i] && ph < BURST_STOP[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // PWM period for a tone; only the listed tones ever occur.
   function automatic logic [PERIOD_W-1:0] tone_period(input logic [HZ_W-1:0] hz);
      logic [PERIOD_W-1:0] p;
      case (hz)
         HZ_200:  p = PER_200;
         HZ_300:  p = PER_300;
         HZ_333:  p = PER_333;
         HZ_500:  p = PER_500;
         HZ_666:  p = PER_666;
         default: p = PER_SILENT;
      endcase
      return p;
   endfunction

endpackage

>>> hw/rtl/buzzer_beep_pattern_sequencer.sv
// Top level of the buzzer beep pattern sequencer: state update, result register and skid stage.

// The sequencer takes one word per cycle on the req_ channel: a 10 ms tick or an event
// (key press, key type, key time, alarm type). Every word yields exactly one rsp_ word with
// the buzzer tone, its PWM period and high counts, and the current key and alarm types.
// A word's whole effect is worked out combinationally by a short compare ladder and countdown
// update, and its result is registered for rsp_, or in the skid stage while rsp_ stalls. The
// result register is backed by a one-word skid stage, so one more word is taken while a result
// waits; req_stall rises only when the skid stage is full. Sustained rate is one word per cycle
// whenever the result side keeps taking words. A key beep has priority: on a tick the key beep
// steps first and the alarm pattern steps only if no key beep is left active. Key press events are
// ignored while csr_write_data last written was 0 (sound disabled); the enable resets to 1.
module buzzer_beep_pattern_sequencer
   import bbps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_write_enable,
   input  logic                csr_write_data,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [KIND_W-1:0]   req_type_code,
   input  logic [COUNT_W-1:0]  req_key_time,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tone_on,
   output logic [HZ_W-1:0]     rsp_tone_hz,
   output logic [PERIOD_W-1:0] rsp_period_count,
   output logic [HIGH_W-1:0]   rsp_high_count,
   output logic                rsp_pwm_written,
   output logic [KIND_W-1:0]   rsp_key_type_now,
   output logic [KIND_W-1:0]   rsp_alarm_type_now
);

   // Sequencer state.
   logic                sound_enable_ff;
   logic [KIND_W-1:0]   key_kind_ff,  key_kind_in;
   logic [COUNT_W-1:0]  key_count_ff, key_count_in;
   logic [KIND_W-1:0]   alarm_kind_ff, alarm_kind_in;
   logic [PHASE_W-1:0]  alarm_phase_ff, alarm_phase_in;
   logic [HZ_W-1:0]     tone_hz_ff, tone_hz_in;

   // Output register and skid stage.
   logic                out_valid_ff;
   rsp_type             out_ff;
   logic                skid_valid_ff;
   rsp_type             skid_ff;

   logic                accept;
   logic                out_take;
   logic                written;
   logic                key_active;
   logic                alarm_run;
   logic [HZ_W-1:0]     alarm_hz;
   logic [PERIOD_W-1:0] period_in;
   rsp_type             result;

   // Only a full skid stage holds off the requester, so req_stall is a plain register.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = !out_valid_ff || !rsp_stall;

   // Next state for one word. The key step runs before the alarm step on a tick.
   always_comb begin
      key_kind_in    = key_kind_ff;
      key_count_in   = key_count_ff;
      alarm_kind_in  = alarm_kind_ff;
      alarm_phase_in = alarm_phase_ff;
      tone_hz_in     = tone_hz_ff;
      written        = 1'b0;
      key_active     = 1'b0;
      alarm_run      = 1'b0;
      alarm_hz       = HZ_SILENT;

      case (req_mode)
         MODE_TICK: begin
            written    = 1'b1;
            key_active = 1'b1;
            case (key_kind_ff)
               KEY_VALID: begin
                  tone_hz_in = (key_count_ff > VALID_TICKS) ? HZ_300 : HZ_200;
               end
               KEY_INVALID: begin
                  // Tone, then a gap of silence, then tone again.
                  if (key_count_ff > INVALID_GAP_HI) begin
                     tone_hz_in = HZ_500;
                  end else if (key_count_ff > INVALID_GAP_LO) begin
                     tone_hz_in = HZ_SILENT;
                  end else begin
                     tone_hz_in = HZ_500;
                  end
               end
               KEY_SERVICE: begin
                  // The service tone reloads its countdown so it never runs out.
                  key_count_in = SERVICE_RELOAD;
                  tone_hz_in   = HZ_333;
               end
               default: begin
                  key_active = 1'b0;
               end
            endcase

            if (key_active) begin
               if (key_count_in == '0) begin
                  tone_hz_in  = HZ_SILENT;
                  key_kind_in = KEY_NONE;
               end else begin
                  key_count_in = key_count_in - COUNT_W'(1);
               end
            end

            // The alarm step runs only when no key beep is left, including on the tick
            // where a key beep has just ended.
            if (key_kind_in == KEY_NONE) begin
               alarm_run = 1'b1;
               case (alarm_kind_ff)
                  ALARM_WARNING: alarm_hz = HZ_666;
                  ALARM_TIPS:    alarm_hz = HZ_333;
                  default:       alarm_run = 1'b0;
               endcase
               if (alarm_run) begin
                  tone_hz_in     = burst_on(alarm_phase_ff) ? alarm_hz : HZ_SILENT;
                  alarm_phase_in = alarm_phase_ff + PHASE_W'(1);
                  if (alarm_phase_in >= PHASE_W'(ALARM_LOOP_TICKS)) begin
                     alarm_phase_in = '0;
                  end
               end else begin
                  tone_hz_in = HZ_SILENT;
               end
            end
         end
         MODE_VALID_KEY: begin
            if (sound_enable_ff) begin
               key_count_in = VALID_TICKS;
               key_kind_in  = KEY_VALID;
            end
         end
         MODE_INVALID_KEY: begin
            if (sound_enable_ff) begin
               key_count_in = INVALID_TICKS;
               key_kind_in  = KEY_INVALID;
            end
         end
         MODE_SET_KEY: begin
            key_kind_in = req_type_code;
         end
         MODE_SET_TIME: begin
            key_count_in = req_key_time;
         end
         MODE_SET_ALARM: begin
            alarm_kind_in  = req_type_code;
            alarm_phase_in = '0;
         end
         default: begin
            // Unused modes change nothing.
         end
      endcase
   end

   // The PWM counts follow from the tone alone.
   assign period_in = tone_period(tone_hz_in);

   always_comb begin
      result.tone_on        = (tone_hz_in != HZ_SILENT);
      result.tone_hz        = tone_hz_in;
      result.period_count   = period_in;
      result.high_count     = (tone_hz_in == HZ_SILENT) ? '0 : period_in[PERIOD_W-1:1];
      result.pwm_written    = written;
      result.key_type_now   = key_kind_in;
      result.alarm_type_now = alarm_kind_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sound_enable_ff <= 1'b1;
         key_kind_ff     <= KEY_NONE;
         key_count_ff    <= '0;
         alarm_kind_ff   <= ALARM_NONE;
         alarm_phase_ff  <= '0;
         tone_hz_ff      <= HZ_SILENT;
      end else begin
         if (csr_write_enable) begin
            sound_enable_ff <= csr_write_data;
         end
         if (accept) begin
            key_kind_ff    <= key_kind_in;
            key_count_ff   <= key_count_in;
            alarm_kind_ff  <= alarm_kind_in;
            alarm_phase_ff <= alarm_phase_in;
            tone_hz_ff     <= tone_hz_in;
         end
      end
   end

   // Output register with skid stage. While the skid stage is full nothing is accepted,
   // so it drains into the output register first.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_tone_on        = out_ff.tone_on;
   assign rsp_tone_hz        = out_ff.tone_hz;
   assign rsp_period_count   = out_ff.period_count;
   assign rsp_high_count     = out_ff.high_count;
   assign rsp_pwm_written    = out_ff.pwm_written;
   assign rsp_key_type_now   = out_ff.key_type_now;
   assign rsp_alarm_type_now = out_ff.alarm_type_now;

`ifndef SYNTH
   // A word in the skid stage always has an older word ahead of it.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a word while the output register is empty");

   // A stalled result with a full skid stage must not move.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(out_ff)))
      else $error("buffered words moved during a stall");

   // Silence means a zero high count and a tone flag that matches the frequency.
   a_tone_consistent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.tone_on == (out_ff.tone_hz != HZ_SILENT)) &&
                        (out_ff.tone_on || out_ff.high_count == '0)))
      else $error("tone flag, frequency and high count disagree");

   // The alarm phase stays inside its loop.
   a_phase_in_loop: assert property (@(posedge clock) disable iff (reset)
      alarm_phase_ff < PHASE_W'(ALARM_LOOP_TICKS))
      else $error("alarm phase left its loop");

   // A service beep keeps its countdown reloaded after every tick.
   a_service_reload: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_TICK && key_kind_ff == KEY_SERVICE)
      |=> (key_count_ff == SERVICE_RELOAD - COUNT_W'(1)))
      else $error("service beep countdown not reloaded");
`endif

endmodule
